[rtl/nmwv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA MWV parser package
// Character codes, status codes, scan state types and small helper functions
// shared by the wind sentence parser.
// ----------------------------------------------------------------------------
package nmwv_pkg;

  localparam int HDR_LEN = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UPPER_R = 8'h52;
  localparam logic [7:0] CH_UPPER_M = 8'h4D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_HEADER      = 4'd1;
  localparam logic [3:0] ST_NO_STAR     = 4'd2;
  localparam logic [3:0] ST_BAD_HEX     = 4'd3;
  localparam logic [3:0] ST_HEX_OVF     = 4'd4;
  localparam logic [3:0] ST_MISMATCH    = 4'd5;
  localparam logic [3:0] ST_NO_DIR      = 4'd6;
  localparam logic [3:0] ST_DIR_DIGITS  = 4'd7;
  localparam logic [3:0] ST_NO_REF      = 4'd8;
  localparam logic [3:0] ST_REF_LETTER  = 4'd9;
  localparam logic [3:0] ST_NO_SPEED    = 4'd10;
  localparam logic [3:0] ST_SPD_DIGITS  = 4'd11;
  localparam logic [3:0] ST_NO_UNITS    = 4'd12;
  localparam logic [3:0] ST_UNITS_LETTER = 4'd13;
  localparam logic [3:0] ST_NO_VALID    = 4'd14;
  localparam logic [3:0] ST_VALID_LETTER = 4'd15;

  localparam logic [2:0] FLD_DIR   = 3'd2;
  localparam logic [2:0] FLD_REF   = 3'd3;
  localparam logic [2:0] FLD_SPEED = 3'd4;
  localparam logic [2:0] FLD_UNITS = 3'd5;
  localparam logic [2:0] FLD_VALID = 3'd6;
  localparam logic [2:0] FLD_LAST  = 3'd7;

  localparam logic [23:0] DIR_CAP   = 24'd32768;
  localparam logic [23:0] SPD_CAP   = 24'd8388608;
  localparam logic [16:0] DIR_POS_MAX = 17'd32767;
  localparam logic [23:0] SPD_POS_MAX = 24'd8388607;
  localparam logic [31:0] HEX_SHIFT_MAX = 32'h0FFF_FFFF;

  typedef struct packed {
    logic       neg;
    logic       started;
    logic       digit;
    logic       frac;
    logic       ended;
    logic [2:0] nfrac;
  } num_flags_t;

  typedef struct packed {
    num_flags_t  fl;
    logic [23:0] acc;
  } num_state_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h24;
      3'd1: r = 8'h57;
      3'd2: r = 8'h49;
      3'd3: r = 8'h4D;
      3'd4: r = 8'h57;
      3'd5: r = 8'h56;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Bit 4 of the result flags a character that is not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (is_dec(c)) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic num_state_t num_feed(input num_state_t s, input logic [7:0] c,
                                          input logic [23:0] cap, input logic is_real,
                                          input logic [2:0] frac_max);
    num_state_t r;
    logic [27:0] v;
    r = s;
    v = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {24'd0, c[3:0]};
    if (!s.fl.ended) begin
      if (is_dec(c)) begin
        r.fl.started = 1'b1;
        r.fl.digit = 1'b1;
        if (!(s.fl.frac && (s.fl.nfrac >= frac_max))) begin
          if (s.fl.frac) begin
            r.fl.nfrac = s.fl.nfrac + 3'd1;
          end
          r.acc = (v > {4'd0, cap}) ? cap : v[23:0];
        end
      end else if (!s.fl.started && is_blank(c)) begin
        r = s;
      end else if (!s.fl.started && (c == CH_PLUS || c == CH_MINUS)) begin
        r.fl.started = 1'b1;
        r.fl.neg = (c == CH_MINUS);
      end else if (is_real && (c == CH_DOT) && !s.fl.frac) begin
        r.fl.started = 1'b1;
        r.fl.frac = 1'b1;
      end else begin
        r.fl.ended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [19:0] pow10(input logic [2:0] k);
    logic [19:0] r;
    case (k)
      3'd0: r = 20'd1;
      3'd1: r = 20'd10;
      3'd2: r = 20'd100;
      3'd3: r = 20'd1000;
      3'd4: r = 20'd10000;
      3'd5: r = 20'd100000;
      3'd6: r = 20'd1000000;
      default: r = 20'd1;
    endcase
    return r;
  endfunction

  // Largest magnitude that stays within the speed cap after scaling by 10^k.
  function automatic logic [23:0] spd_limit(input logic [2:0] k);
    logic [23:0] r;
    case (k)
      3'd0: r = 24'd8388608;
      3'd1: r = 24'd838860;
      3'd2: r = 24'd83886;
      3'd3: r = 24'd8388;
      3'd4: r = 24'd838;
      3'd5: r = 24'd83;
      3'd6: r = 24'd8;
      default: r = 24'd8388608;
    endcase
    return r;
  endfunction

endpackage

[rtl/nmea_mwv_wind_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA MWV wind sentence parser
// Checks header and checksum of an MWV sentence and extracts wind direction
// and speed, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one sentence character per transaction, with
//   in_end_of_message high on the final character. Every character updates
//   the header, checksum and field scan state, so one character is taken in
//   every clock cycle while in_stall is low.
//   Only the final character produces a transaction on the output channel:
//   a status code and, when the status is zero, the direction in degrees and
//   the speed in thousandths of m/s. After the final character is taken,
//   one register holds the finished scan state and the output register
//   holds the scaled values, with the speed scaling multiplier between them.
//   The output register and the stage before it decouple the two sides, so
//   input is stalled only while both hold a result and out_stall is high.
//   After the final character the scan state returns to its reset values.
//   Reset is synchronous and active low; it clears the scan state and the
//   valid flags of both result stages.
// ----------------------------------------------------------------------------
module nmea_mwv_wind_parser #(
  parameter int MAX_SENTENCE_BYTES = 512,
  parameter int SPEED_FRACTION_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic signed [15:0] out_wind_direction,
  output logic signed [23:0] out_wind_speed_milli
);
  import nmwv_pkg::*;

  localparam int POS_W = $clog2(MAX_SENTENCE_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SENTENCE_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(HDR_LEN);
  localparam logic [2:0] FRAC_MAX = 3'(SPEED_FRACTION_DIGITS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic        header_ok_r, header_ok_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        star_r, star_nxt;
  logic [31:0] hex_r, hex_nxt;
  logic        hex_digit_r, hex_digit_nxt;
  logic        hex_ovf_r, hex_ovf_nxt;
  logic        hex_done_r, hex_done_nxt;
  logic [2:0]  field_r, field_nxt;
  logic        sep_r, sep_nxt;
  num_state_t  dir_r, dir_nxt;
  num_state_t  spd_r, spd_nxt;
  logic [2:0]  letters_r, letters_nxt;

  logic        in_acc, out_free, snap_free;
  logic [4:0]  hex_d;
  logic        first;
  num_state_t  dir_fed, spd_fed;
  logic [3:0]  status_now;

  logic        snap_valid_r;
  logic [3:0]  snap_status_r;
  logic        snap_dir_neg_r;
  logic [16:0] snap_dir_acc_r;
  logic        snap_spd_neg_r;
  logic [23:0] snap_spd_acc_r;
  logic [2:0]  snap_scale_r;

  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [15:0] out_dir_r;
  logic [23:0] out_spd_r;

  logic [43:0] spd_prod;
  logic [23:0] spd_mag;
  logic [15:0] dir_val;
  logic [23:0] spd_val;

  assign out_free = !out_valid_r || !out_stall;
  assign snap_free = !snap_valid_r || out_free;
  assign in_stall = !snap_free;
  assign in_acc = in_valid && !in_stall;

  assign hex_d = hex_decode(in_data_byte);
  assign dir_fed = num_feed(dir_r, in_data_byte, DIR_CAP, 1'b0, FRAC_MAX);
  assign spd_fed = num_feed(spd_r, in_data_byte, SPD_CAP, 1'b1, FRAC_MAX);

  always_comb begin
    pos_nxt = pos_r;
    header_ok_nxt = header_ok_r;
    xor_nxt = xor_r;
    star_nxt = star_r;
    hex_nxt = hex_r;
    hex_digit_nxt = hex_digit_r;
    hex_ovf_nxt = hex_ovf_r;
    hex_done_nxt = hex_done_r;
    field_nxt = field_r;
    sep_nxt = sep_r;
    dir_nxt = dir_r;
    spd_nxt = spd_r;
    letters_nxt = letters_r;
    first = 1'b0;
    if (pos_r < POS_LAST) begin
      if ((pos_r < POS_HDR) && (in_data_byte != hdr_char(pos_r[2:0]))) begin
        header_ok_nxt = 1'b0;
      end
      if (in_data_byte == CH_NUL) begin
        pos_nxt = POS_LAST;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (!star_r) begin
          if (in_data_byte == CH_STAR) begin
            star_nxt = 1'b1;
          end else if (in_data_byte != CH_DOLLAR) begin
            xor_nxt = xor_r ^ in_data_byte;
          end
        end else if (!hex_done_r) begin
          if (!hex_d[4]) begin
            hex_digit_nxt = 1'b1;
            if (hex_r > HEX_SHIFT_MAX) begin
              hex_ovf_nxt = 1'b1;
            end else begin
              hex_nxt = {hex_r[27:0], hex_d[3:0]};
            end
          end else begin
            hex_done_nxt = 1'b1;
          end
        end
        if (in_data_byte == CH_COMMA) begin
          sep_nxt = 1'b1;
        end else begin
          if (sep_r) begin
            sep_nxt = 1'b0;
            first = 1'b1;
            if (field_r < FLD_LAST) begin
              field_nxt = field_r + 3'd1;
            end
          end
          case (field_nxt)
            FLD_DIR: dir_nxt = dir_fed;
            FLD_REF: begin
              if (first && in_data_byte == CH_UPPER_R) letters_nxt[0] = 1'b1;
            end
            FLD_SPEED: spd_nxt = spd_fed;
            FLD_UNITS: begin
              if (first && in_data_byte == CH_UPPER_M) letters_nxt[1] = 1'b1;
            end
            FLD_VALID: begin
              if (first && in_data_byte == CH_UPPER_A) letters_nxt[2] = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    if (!header_ok_nxt || (pos_nxt < POS_HDR)) status_now = ST_HEADER;
    else if (!star_nxt) status_now = ST_NO_STAR;
    else if (!hex_digit_nxt) status_now = ST_BAD_HEX;
    else if (hex_ovf_nxt) status_now = ST_HEX_OVF;
    else if (hex_nxt != {24'd0, xor_nxt}) status_now = ST_MISMATCH;
    else if (field_nxt < FLD_DIR) status_now = ST_NO_DIR;
    else if (!dir_nxt.fl.digit) status_now = ST_DIR_DIGITS;
    else if (field_nxt < FLD_REF) status_now = ST_NO_REF;
    else if (!letters_nxt[0]) status_now = ST_REF_LETTER;
    else if (field_nxt < FLD_SPEED) status_now = ST_NO_SPEED;
    else if (!spd_nxt.fl.digit) status_now = ST_SPD_DIGITS;
    else if (field_nxt < FLD_UNITS) status_now = ST_NO_UNITS;
    else if (!letters_nxt[1]) status_now = ST_UNITS_LETTER;
    else if (field_nxt < FLD_VALID) status_now = ST_NO_VALID;
    else if (!letters_nxt[2]) status_now = ST_VALID_LETTER;
    else status_now = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_end_of_message)) begin
      pos_r <= '0;
      header_ok_r <= 1'b1;
      xor_r <= '0;
      star_r <= 1'b0;
      hex_r <= '0;
      hex_digit_r <= 1'b0;
      hex_ovf_r <= 1'b0;
      hex_done_r <= 1'b0;
      field_r <= '0;
      sep_r <= 1'b1;
      dir_r <= '0;
      spd_r <= '0;
      letters_r <= '0;
    end else if (in_acc) begin
      pos_r <= pos_nxt;
      header_ok_r <= header_ok_nxt;
      xor_r <= xor_nxt;
      star_r <= star_nxt;
      hex_r <= hex_nxt;
      hex_digit_r <= hex_digit_nxt;
      hex_ovf_r <= hex_ovf_nxt;
      hex_done_r <= hex_done_nxt;
      field_r <= field_nxt;
      sep_r <= sep_nxt;
      dir_r <= dir_nxt;
      spd_r <= spd_nxt;
      letters_r <= letters_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_free) begin
      snap_valid_r <= in_acc && in_end_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_free) begin
      snap_status_r <= status_now;
      snap_dir_neg_r <= dir_nxt.fl.neg;
      snap_dir_acc_r <= dir_nxt.acc[16:0];
      snap_spd_neg_r <= spd_nxt.fl.neg;
      snap_spd_acc_r <= spd_nxt.acc;
      snap_scale_r <= FRAC_MAX - spd_nxt.fl.nfrac;
    end
  end

  assign spd_prod = {20'd0, snap_spd_acc_r} * {24'd0, pow10(snap_scale_r)};
  assign spd_mag = (snap_spd_acc_r > spd_limit(snap_scale_r)) ? SPD_CAP : spd_prod[23:0];

  always_comb begin
    if (snap_dir_neg_r) begin
      dir_val = 16'(17'd0 - snap_dir_acc_r);
    end else if (snap_dir_acc_r > DIR_POS_MAX) begin
      dir_val = DIR_POS_MAX[15:0];
    end else begin
      dir_val = snap_dir_acc_r[15:0];
    end
    if (snap_spd_neg_r) begin
      spd_val = 24'd0 - spd_mag;
    end else if (spd_mag > SPD_POS_MAX) begin
      spd_val = SPD_POS_MAX;
    end else begin
      spd_val = spd_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_status_r <= snap_status_r;
      out_dir_r <= (snap_status_r == ST_OK) ? dir_val : '0;
      out_spd_r <= (snap_status_r == ST_OK) ? spd_val : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_wind_direction = out_dir_r;
  assign out_wind_speed_milli = out_spd_r;

endmodule

[tb/nmwv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MWV parser scoreboard
// Follows every accepted sentence character with its own scan of header,
// checksum and fields, queues the expected report for each final character
// and compares the reports leaving the parser field by field.
// ----------------------------------------------------------------------------
module nmwv_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_message,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         out_status,
  input  logic signed [15:0] out_wind_direction,
  input  logic signed [23:0] out_wind_speed_milli,
  output int                 fail_count,
  output int                 reports_pending,
  output int                 reports_checked,
  output logic [15:0]        status_mask
);
  import nmwv_pkg::*;

  localparam int MAX_BYTES = 512;
  localparam int FRAC_DIGITS = 3;
  localparam logic [23:0] DIR_LIMIT = 24'd32768;
  localparam logic [23:0] SPD_LIMIT = 24'd8388608;
  localparam logic [47:0] HDR_TEXT = "$WIMWV";

  typedef struct packed {
    logic        neg;
    logic        begun;
    logic        has_digit;
    logic        in_frac;
    logic        done;
    logic [2:0]  frac_n;
    logic [23:0] mag;
  } numscan_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [15:0] direction;
    logic signed [23:0] speed;
  } wind_report_t;

  wind_report_t wind_reports_q[$];

  int         char_count;
  logic       hdr_good;
  logic [7:0] xsum;
  logic       star;
  logic [31:0] hexv;
  logic       hex_dig;
  logic       hex_ovf;
  logic       hex_done;
  logic [2:0] fld;
  logic       sep;
  logic       ref_ok;
  logic       units_ok;
  logic       valid_ok;
  numscan_t   dir_s;
  numscan_t   spd_s;

  task automatic clear_scan();
    char_count = 0;
    hdr_good = 1'b1;
    xsum = '0;
    star = 1'b0;
    hexv = '0;
    hex_dig = 1'b0;
    hex_ovf = 1'b0;
    hex_done = 1'b0;
    fld = '0;
    sep = 1'b1;
    ref_ok = 1'b0;
    units_ok = 1'b0;
    valid_ok = 1'b0;
    dir_s = '0;
    spd_s = '0;
  endtask

  function automatic numscan_t scan_num(input numscan_t s, input logic [7:0] c,
                                        input logic [23:0] cap, input logic allow_point);
    numscan_t r;
    logic [31:0] v;
    r = s;
    v = 32'(s.mag) * 32'd10 + 32'(c - "0");
    if (!s.done) begin
      if (c >= "0" && c <= "9") begin
        r.begun = 1'b1;
        r.has_digit = 1'b1;
        if (!(s.in_frac && s.frac_n >= FRAC_DIGITS)) begin
          if (s.in_frac) begin
            r.frac_n = s.frac_n + 3'd1;
          end
          r.mag = (v > 32'(cap)) ? cap : v[23:0];
        end
      end else if (!s.begun && (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D))) begin
        r = s;
      end else if (!s.begun && (c == CH_PLUS || c == CH_MINUS)) begin
        r.begun = 1'b1;
        r.neg = (c == CH_MINUS);
      end else if (allow_point && c == CH_DOT && !s.in_frac) begin
        r.begun = 1'b1;
        r.in_frac = 1'b1;
      end else begin
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic scan_char(input logic [7:0] c);
    logic       first;
    logic [4:0] d;
    first = 1'b0;
    d = 5'd16;
    if (!star) begin
      if (c == CH_STAR) begin
        star = 1'b1;
      end else if (c != CH_DOLLAR) begin
        xsum = xsum ^ c;
      end
    end else if (!hex_done) begin
      if (c >= "0" && c <= "9") begin
        d = 5'(c - "0");
      end else if (c >= "a" && c <= "f") begin
        d = 5'(c - "a") + 5'd10;
      end else if (c >= "A" && c <= "F") begin
        d = 5'(c - "A") + 5'd10;
      end
      if (d < 5'd16) begin
        hex_dig = 1'b1;
        if (hexv > 32'h0FFF_FFFF) begin
          hex_ovf = 1'b1;
        end else begin
          hexv = {hexv[27:0], d[3:0]};
        end
      end else begin
        hex_done = 1'b1;
      end
    end

    if (c == CH_COMMA) begin
      sep = 1'b1;
    end else begin
      if (sep) begin
        sep = 1'b0;
        if (fld < FLD_LAST) begin
          fld = fld + 3'd1;
        end
        first = 1'b1;
      end
      case (fld)
        FLD_DIR: dir_s = scan_num(dir_s, c, DIR_LIMIT, 1'b0);
        FLD_REF: if (first && c == CH_UPPER_R) ref_ok = 1'b1;
        FLD_SPEED: spd_s = scan_num(spd_s, c, SPD_LIMIT, 1'b1);
        FLD_UNITS: if (first && c == CH_UPPER_M) units_ok = 1'b1;
        FLD_VALID: if (first && c == CH_UPPER_A) valid_ok = 1'b1;
        default: ;
      endcase
    end
  endtask

  function automatic logic [3:0] sentence_status();
    logic [3:0] st;
    if (!hdr_good || char_count < 6) st = ST_HEADER;
    else if (!star) st = ST_NO_STAR;
    else if (!hex_dig) st = ST_BAD_HEX;
    else if (hex_ovf) st = ST_HEX_OVF;
    else if (hexv != {24'd0, xsum}) st = ST_MISMATCH;
    else if (fld < FLD_DIR) st = ST_NO_DIR;
    else if (!dir_s.has_digit) st = ST_DIR_DIGITS;
    else if (fld < FLD_REF) st = ST_NO_REF;
    else if (!ref_ok) st = ST_REF_LETTER;
    else if (fld < FLD_SPEED) st = ST_NO_SPEED;
    else if (!spd_s.has_digit) st = ST_SPD_DIGITS;
    else if (fld < FLD_UNITS) st = ST_NO_UNITS;
    else if (!units_ok) st = ST_UNITS_LETTER;
    else if (fld < FLD_VALID) st = ST_NO_VALID;
    else if (!valid_ok) st = ST_VALID_LETTER;
    else st = ST_OK;
    return st;
  endfunction

  task automatic predict_char(input logic [7:0] c, input logic last);
    wind_report_t rep;
    logic [16:0]  dneg;
    logic [24:0]  sneg;
    logic [31:0]  m;
    int           n;
    if (char_count < MAX_BYTES - 1) begin
      if (char_count < 6 && c != HDR_TEXT[8 * (5 - char_count) +: 8]) begin
        hdr_good = 1'b0;
      end
      if (c == CH_NUL) begin
        char_count = MAX_BYTES - 1;
      end else begin
        char_count++;
        scan_char(c);
      end
    end
    if (last) begin
      rep = '0;
      rep.status = sentence_status();
      if (rep.status == ST_OK) begin
        if (dir_s.neg) begin
          dneg = 17'h10000 - 17'(dir_s.mag);
          rep.direction = dneg[15:0];
        end else begin
          rep.direction = (dir_s.mag > 24'd32767) ? 16'sd32767 : dir_s.mag[15:0];
        end
        m = 32'(spd_s.mag);
        for (n = int'(spd_s.frac_n); n < FRAC_DIGITS; n++) begin
          m = (m * 32'd10 > 32'(SPD_LIMIT)) ? 32'(SPD_LIMIT) : m * 32'd10;
        end
        if (spd_s.neg) begin
          sneg = 25'h1000000 - 25'(m);
          rep.speed = sneg[23:0];
        end else begin
          rep.speed = (m > 32'd8388607) ? 24'sd8388607 : m[23:0];
        end
      end
      wind_reports_q.push_back(rep);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    wind_report_t want;
    if (!rst_n) begin
      clear_scan();
      wind_reports_q.delete();
      fail_count = 0;
      reports_checked = 0;
      status_mask = '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_char(in_data_byte, in_end_of_message);
      end
      if (out_valid && !out_stall) begin
        if (wind_reports_q.size() == 0) begin
          $error("Unexpected result transaction with out_status %0d.", out_status);
          fail_count++;
        end else begin
          want = wind_reports_q.pop_front();
          reports_checked++;
          status_mask[want.status] = 1'b1;
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_wind_direction !== want.direction) begin
            $error("out_wind_direction: expected %0d, actual %0d", want.direction,
                   out_wind_direction);
            fail_count++;
          end
          if (out_wind_speed_milli !== want.speed) begin
            $error("out_wind_speed_milli: expected %0d, actual %0d", want.speed,
                   out_wind_speed_milli);
            fail_count++;
          end
        end
      end
    end
    reports_pending = wind_reports_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MWV parser testbench
// Feeds directed and randomized wind sentences, noise and damaged text into
// the parser under bursty input and a stalling receiver, and reports the
// verdict from the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import nmwv_pkg::*;

  typedef enum int {SUM_UPPER, SUM_LOWER, SUM_PADDED, SUM_WRONG, SUM_HUGE, SUM_EMPTY,
                    SUM_NONE} sum_style_t;
  typedef enum int {RX_FREE, RX_SPOTTY, RX_HEAVY} rx_mode_t;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_data_byte;
  logic               in_end_of_message;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         out_status;
  logic signed [15:0] out_wind_direction;
  logic signed [23:0] out_wind_speed_milli;

  int          fail_count;
  int          reports_pending;
  int          reports_checked;
  logic [15:0] status_mask;

  logic [7:0] msg_q[$];
  int         bytes_sent;
  int         msgs_sent;
  int         burst_left;
  logic       calm;

  nmea_mwv_wind_parser u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_end_of_message   (in_end_of_message),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_wind_direction  (out_wind_direction),
    .out_wind_speed_milli(out_wind_speed_milli)
  );

  nmwv_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_end_of_message   (in_end_of_message),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_wind_direction  (out_wind_direction),
    .out_wind_speed_milli(out_wind_speed_milli),
    .fail_count          (fail_count),
    .reports_pending     (reports_pending),
    .reports_checked     (reports_checked),
    .status_mask         (status_mask)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      msg_q.push_back(s[i]);
    end
  endtask

  function automatic logic [7:0] body_xor();
    logic [7:0] x;
    x = '0;
    foreach (msg_q[i]) begin
      if (msg_q[i] == CH_STAR) break;
      if (msg_q[i] != CH_DOLLAR) x = x ^ msg_q[i];
    end
    return x;
  endfunction

  task automatic add_sum(input sum_style_t style);
    logic [7:0] x;
    string      h;
    x = body_xor();
    h = $sformatf("%h", x);
    if (style != SUM_NONE) begin
      msg_q.push_back(CH_STAR);
      case (style)
        SUM_UPPER: add_text(h.toupper());
        SUM_LOWER: add_text(h);
        SUM_PADDED: add_text({"00000000", h.toupper()});
        SUM_WRONG: add_text($sformatf("%h", x ^ 8'($urandom_range(1, 255))));
        SUM_HUGE: add_text({"1", $sformatf("%h", $urandom)});
        default: ;
      endcase
    end
  endtask

  task automatic add_crlf();
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
  endtask

  // The sender runs in bursts; calm sentences go out back to back.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (!calm && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_message <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) begin
      push_byte(msg_q[i], i == msg_q.size() - 1);
    end
    msgs_sent++;
  endtask

  task automatic send_text(input string s, input sum_style_t style);
    msg_q.delete();
    add_text(s);
    add_sum(style);
    send_msg();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (reports_pending != 0) @(negedge clk);
  endtask

  function automatic string rand_digits(input int k);
    string s;
    s = "";
    repeat (k) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic string rand_dir();
    string s;
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(0, 359));
      5: s = $sformatf("-%0d", $urandom_range(0, 40000));
      6: s = $sformatf("%0d", $urandom_range(30000, 99999999));
      7: s = $sformatf(" \t+%0d", $urandom_range(0, 999));
      8: s = $sformatf("%0d.%0d", $urandom_range(0, 359), $urandom_range(0, 9));
      9: s = $sformatf("%0d", $urandom);
      10: s = "-";
      default: s = "N";
    endcase
    return s;
  endfunction

  function automatic string rand_speed();
    string ip, fp, s;
    if ($urandom_range(0, 3) == 0) ip = $sformatf("%0d", $urandom_range(0, 99999999));
    else ip = $sformatf("%0d", $urandom_range(0, 99));
    fp = rand_digits($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: s = (fp.len() > 0) ? {ip, ".", fp} : ip;
      6: s = {"-", ip, ".", fp};
      7: s = {" +", ip};
      8: s = {".", fp};
      default: begin
        case ($urandom_range(0, 2))
          0: s = "nan";
          1: s = "1.2.3";
          default: s = "-.";
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic string rand_flag(input string good);
    string s;
    case ($urandom_range(0, 15))
      0: s = "";
      1: s = good.tolower();
      2: s = "X";
      3: s = {good, "x"};
      default: s = good;
    endcase
    return s;
  endfunction

  task automatic make_wind_msg(input logic long_one);
    sum_style_t style;
    logic [7:0] filler;
    msg_q.delete();
    add_text("$WIMWV");
    if (long_one) begin
      filler = ($urandom_range(0, 1) == 0) ? CH_COMMA : CH_SPACE;
      msg_q.push_back(CH_COMMA);
      repeat ($urandom_range(495, 540)) msg_q.push_back(filler);
    end
    if ($urandom_range(0, 9) == 0) add_text(",,");
    add_text({",", rand_dir(), ",", rand_flag("R"), ",", rand_speed(), ",",
              rand_flag("M"), ",", rand_flag("A")});
    if ($urandom_range(0, 9) == 0) add_text(",X,1");
    case ($urandom_range(0, 19))
      0: style = SUM_NONE;
      1: style = SUM_EMPTY;
      2: style = SUM_HUGE;
      3, 4: style = SUM_WRONG;
      5, 6: style = SUM_LOWER;
      7: style = SUM_PADDED;
      default: style = SUM_UPPER;
    endcase
    add_sum(style);
    if ($urandom_range(0, 1) == 0) add_crlf();
    if ($urandom_range(0, 11) == 0) begin
      msg_q[$urandom_range(0, msg_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 29) == 0) begin
      msg_q.insert($urandom_range(0, msg_q.size() - 1), CH_NUL);
    end
  endtask

  task automatic make_noise_msg();
    msg_q.delete();
    if ($urandom_range(0, 1) == 0) add_text("$WIMWV");
    repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rx_mode_t mode;
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 2))
        0: mode = RX_FREE;
        1: mode = RX_SPOTTY;
        default: mode = RX_HEAVY;
      endcase
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        case (mode)
          RX_FREE: out_stall <= 1'b0;
          RX_SPOTTY: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int rand_start;
    int rand_msgs;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_message = 1'b0;
    bytes_sent = 0;
    msgs_sent = 0;
    burst_left = 0;
    calm = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("$WIMWV,270,R,12.5,M,A", SUM_UPPER);
    send_text("$WIMWV,-32768,R,-8388.608,M,A", SUM_LOWER);
    send_text("$WIMWV,99999,R,99999999,M,A", SUM_PADDED);
    send_text("$WIMWV,,, \t+0,R, 1.23456,M,A", SUM_UPPER);
    send_text("$GPMWV,1,R,1,M,A", SUM_UPPER);
    send_text("$WI", SUM_NONE);
    send_text("$WIMWV,1,R,1,M,A", SUM_NONE);
    send_text("$WIMWV,1,R,1,M,A", SUM_EMPTY);
    send_text("$WIMWV,1,R,1,M,A", SUM_HUGE);
    send_text("$WIMWV,1,R,1,M,A", SUM_WRONG);
    send_text("$WIMWV", SUM_UPPER);
    send_text("$WIMWV,abc,R,1,M,A", SUM_UPPER);
    send_text("$WIMWV,10", SUM_UPPER);
    send_text("$WIMWV,10,T,1,M,A", SUM_UPPER);
    send_text("$WIMWV,10,R", SUM_UPPER);
    send_text("$WIMWV,10,R,nan,M,A", SUM_UPPER);
    send_text("$WIMWV,10,R,5", SUM_UPPER);
    send_text("$WIMWV,10,R,5,K,A", SUM_UPPER);
    send_text("$WIMWV,10,R,5,M", SUM_UPPER);
    send_text("$WIMWV,10,R,5,M,V", SUM_UPPER);

    msg_q.delete();
    add_text("$WIMWV,7,R,7,M,A,extra");
    add_sum(SUM_UPPER);
    add_crlf();
    send_msg();

    msg_q.delete();
    add_text("$WI");
    msg_q.push_back(CH_NUL);
    add_text("MWV,1,R,1,M,A");
    add_sum(SUM_UPPER);
    send_msg();

    msg_q.delete();
    add_text("$WIMWV,1,R,1,M,A");
    msg_q.push_back(CH_NUL);
    add_sum(SUM_UPPER);
    send_msg();

    msg_q.delete();
    msg_q.push_back(8'hFF);
    msg_q.push_back(8'h80);
    msg_q.push_back(8'h7F);
    send_msg();

    make_wind_msg(1'b1);
    send_msg();
    wait_drained();

    rand_start = bytes_sent;
    rand_msgs = 0;
    while ((bytes_sent - rand_start) < 400 || rand_msgs < 12) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0, 1: make_noise_msg();
        2: make_wind_msg($urandom_range(0, 2) == 0);
        default: make_wind_msg(1'b0);
      endcase
      send_msg();
      rand_msgs++;
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("Run covered %0d sentences in %0d characters; %0d reports compared.",
             msgs_sent, bytes_sent, reports_checked);
    $display("Reports reached %0d of the 16 status codes.", $countones(status_mask));
    if (fail_count == 0 && reports_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
